/* hw/rtl/quaternion_to_euler_angles_macros.svh */
// Assertion helpers for the RTL, used by qte_back.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/qte_pkg.sv */
`default_nettype none
package qte_pkg;

    localparam int CW     = 48;  // CORDIC x/y, Q30 with headroom
    localparam int AW     = 34;  // angle accumulator, 2^-32 turn
    localparam int QW     = 32;  // clamped pitch term in Q30
    localparam int RW     = 61;  // 2^60 - t2q^2
    localparam int PW     = 51;  // angle times degree scale
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    localparam logic signed [AW-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [16:0]   DEG_SCALE = 17'sd46080;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [AW-1:0] t_ang;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_ang   ang;
        logic   zero;
    } t_lane;

    typedef struct packed {
        t_coord                roll_y;
        t_coord                roll_x;
        t_coord                yaw_y;
        t_coord                yaw_x;
        logic signed [QW-1:0]  t2q;
        logic [RW-1:0]         rem;
        logic                  clamped;
    } t_qent;

    function automatic t_ang atan_val(input logic [4:0] i);
        t_ang v;
        unique case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Left half-plane vectors are turned by 180 degrees first.
    function automatic t_lane cordic_init(input t_coord y, input t_coord x);
        t_lane l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            l.ang = (y >= 0) ? HALF_TURN : -HALF_TURN;
            l.x   = -x;
            l.y   = -y;
        end else begin
            l.ang = '0;
            l.x   = x;
            l.y   = y;
        end
        return l;
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input logic [4:0] i);
        t_lane  r;
        t_coord xs;
        t_coord ys;
        xs = l.x >>> i;
        ys = l.y >>> i;
        r.zero = l.zero;
        if (l.y >= 0) begin
            r.x   = l.x + ys;
            r.y   = l.y - xs;
            r.ang = l.ang + atan_val(i);
        end else begin
            r.x   = l.x - ys;
            r.y   = l.y + xs;
            r.ang = l.ang - atan_val(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/quaternion_to_euler_angles.sv */
`default_nettype none
// Quaternion (w, x, y, z, signed Q1.QUAT_FRAC_BITS) to ZYX roll / pitch / yaw.
// Input: pulse start with the four components; the item is taken on any
// clock edge where start is high and busy is low.
// Output: o_valid is high for one cycle with o_roll_angle, o_pitch_angle,
// o_yaw_angle (1/128 degree) and o_pitch_clamped. Results come out in
// input order and cannot be held off; the receiver must take them.
// The front end forms the t terms in a 3-stage multiplier pipe and feeds a
// 4-entry queue; busy rises when the items in the queue and pipe together fill its slots.
// The back end runs one item at a time: a pop from the queue, the
// square root (one root bit per cycle, roll and yaw CORDIC in parallel),
// the pitch CORDIC, then scaling and saturation in S_MUL and S_FIN,
// with min(CORDIC_ITERATIONS, 24) steps in each CORDIC.
// New items are taken while the back end works on an earlier one, as
// long as busy is low.
// Reset (synchronous, active low) empties the queue and pipe and drops
// any item in flight; no result is shown during or right after reset.
module quaternion_to_euler_angles #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int QUAT_FRAC_BITS    = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_q_w,
    input  wire logic signed [15:0] i_q_x,
    input  wire logic signed [15:0] i_q_y,
    input  wire logic signed [15:0] i_q_z,
    output logic                    o_valid,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic signed [15:0]      o_yaw_angle,
    output logic                    o_pitch_clamped
);
    import qte_pkg::*;

    logic push, pop, q_empty;
    t_qent push_ent, head_ent;
    logic [QCW-1:0] q_count;

    qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_q_w     (i_q_w),
        .i_q_x     (i_q_x),
        .i_q_y     (i_q_y),
        .i_q_z     (i_q_z),
        .i_q_count (q_count),
        .o_push    (push),
        .o_ent     (push_ent)
    );

    qte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_ent   (head_ent),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    qte_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_ent           (head_ent),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_roll_angle    (o_roll_angle),
        .o_pitch_angle   (o_pitch_angle),
        .o_yaw_angle     (o_yaw_angle),
        .o_pitch_clamped (o_pitch_clamped)
    );

endmodule
`default_nettype wire

/* hw/rtl/qte_front.sv */
`default_nettype none
module qte_front #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [15:0]       i_q_w,
    input  wire logic signed [15:0]       i_q_x,
    input  wire logic signed [15:0]       i_q_y,
    input  wire logic signed [15:0]       i_q_z,
    input  wire logic [qte_pkg::QCW-1:0]  i_q_count,
    output logic                          o_push,
    output qte_pkg::t_qent                o_ent
);
    import qte_pkg::*;

    localparam int FB2 = 2 * QUAT_FRAC_BITS;
    localparam int SHR = (FB2 > 30) ? FB2 - 30 : 0;
    localparam int SHL = (FB2 < 30) ? 30 - FB2 : 0;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FB2;

    logic accept;
    logic [QCW-1:0] used;

    logic r_v1, r_v2, r_v3;
    logic signed [31:0] r_p_yy, r_p_zz, r_p_xx, r_p_xy, r_p_wz;
    logic signed [31:0] r_p_wy, r_p_xz, r_p_yz, r_p_wx;
    t_coord r_ry, r_rx, r_wy, r_wx;
    logic signed [QW-1:0] r_t2q;
    logic [30:0] r_abs;
    logic r_clp;
    t_qent r_ent;

    logic signed [63:0] t0, t1, t2, t3, t4, t2c, t2q64;
    logic clp;
    logic [61:0] sq;

    function automatic t_coord to_q30(input logic signed [63:0] t);
        logic signed [63:0] s;
        s = (t >>> SHR) <<< SHL;
        return t_coord'(s);
    endfunction

    // Every item in the pipe or the queue holds a queue slot.
    assign used   = i_q_count + QCW'(r_v1) + QCW'(r_v2) + QCW'(r_v3);
    assign busy   = used >= QCW'(QDEPTH);
    assign accept = start && !busy;

    always_comb begin
        t0 = ONE - ((64'(r_p_yy) + 64'(r_p_zz)) <<< 1);
        t1 = (64'(r_p_xy) + 64'(r_p_wz)) <<< 1;
        t2 = (64'(r_p_wy) - 64'(r_p_xz)) <<< 1;
        t3 = (64'(r_p_yz) + 64'(r_p_wx)) <<< 1;
        t4 = ONE - ((64'(r_p_xx) + 64'(r_p_yy)) <<< 1);
        priority if (t2 > ONE) begin
            t2c = ONE;
            clp = 1'b1;
        end else if (t2 < -ONE) begin
            t2c = -ONE;
            clp = 1'b1;
        end else begin
            t2c = t2;
            clp = 1'b0;
        end
        t2q64 = (t2c >>> SHR) <<< SHL;
    end

    assign sq = r_abs * r_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_yy <= i_q_y * i_q_y;
            r_p_zz <= i_q_z * i_q_z;
            r_p_xx <= i_q_x * i_q_x;
            r_p_xy <= i_q_x * i_q_y;
            r_p_wz <= i_q_w * i_q_z;
            r_p_wy <= i_q_w * i_q_y;
            r_p_xz <= i_q_x * i_q_z;
            r_p_yz <= i_q_y * i_q_z;
            r_p_wx <= i_q_w * i_q_x;
        end
        if (r_v1) begin
            r_ry  <= to_q30(t3);
            r_rx  <= to_q30(t4);
            r_wy  <= to_q30(t1);
            r_wx  <= to_q30(t0);
            r_t2q <= QW'(t2q64);
            r_abs <= (t2q64 < 0) ? 31'(-t2q64) : 31'(t2q64);
            r_clp <= clp;
        end
        if (r_v2) begin
            r_ent.roll_y  <= r_ry;
            r_ent.roll_x  <= r_rx;
            r_ent.yaw_y   <= r_wy;
            r_ent.yaw_x   <= r_wx;
            r_ent.t2q     <= r_t2q;
            r_ent.rem     <= RW'((62'd1 << 60) - sq);
            r_ent.clamped <= r_clp;
        end
    end

    assign o_push = r_v3;
    assign o_ent  = r_ent;

endmodule
`default_nettype wire

/* hw/rtl/qte_queue.sv */
`default_nettype none
module qte_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire qte_pkg::t_qent           i_ent,
    input  wire logic                     i_pop,
    output qte_pkg::t_qent                o_ent,
    output logic                          o_empty,
    output logic [qte_pkg::QCW-1:0]       o_count
);
    import qte_pkg::*;

    t_qent r_mem [QDEPTH];
    logic [QPW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPW'(1);
            if (i_pop)  r_rd <= r_rd + QPW'(1);
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_ent;
    end

    assign o_ent   = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

/* hw/rtl/qte_back.sv */
`default_nettype none
`include "quaternion_to_euler_angles_macros.svh"
module qte_back #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire qte_pkg::t_qent      i_ent,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic signed [15:0]       o_roll_angle,
    output logic signed [14:0]       o_pitch_angle,
    output logic signed [15:0]       o_yaw_angle,
    output logic                     o_pitch_clamped
);
    import qte_pkg::*;

    localparam int NI = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam logic [4:0] LAST_IT = 5'(NI - 1);
    localparam logic [4:0] SQ_LAST = 5'd31;
    localparam logic signed [14:0] PITCH_LIM = 15'sd11520;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_PITCH = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [4:0] r_cnt;
    t_lane r_roll, r_yaw, r_pitch;
    logic [RW-1:0] r_sv;
    logic [62:0] r_sr, r_sb;
    logic signed [QW-1:0] r_t2q;
    logic r_clp;
    logic signed [PW-1:0] r_m_roll, r_m_yaw, r_m_pitch;
    logic r_valid;
    logic signed [15:0] r_o_roll, r_o_yaw;
    logic signed [14:0] r_o_pitch;
    logic r_o_clp;

    logic [62:0] sq_sum;
    logic sq_ge;
    logic [RW-1:0] sq_v;
    logic [62:0] sq_r;
    logic root_last;

    // d = floor((a * 46080 + 2^31) / 2^32), saturated to +-lim
    function automatic logic signed [18:0] to_deg(input logic signed [PW-1:0] p,
                                                  input logic signed [18:0] lim);
        logic signed [PW-1:0] d;
        d = (p + 51'sd2147483648) >>> 32;
        priority if (d > PW'(lim))  return lim;
        else if (d < -PW'(lim))     return -lim;
        else                        return 19'(d);
    endfunction

    // Floor square root, one result bit per cycle.
    assign sq_sum = r_sr + r_sb;
    assign sq_ge  = {2'b00, r_sv} >= sq_sum;
    assign sq_v   = sq_ge ? RW'({2'b00, r_sv} - sq_sum) : r_sv;
    assign sq_r   = sq_ge ? (r_sr >> 1) + r_sb : r_sr >> 1;

    assign root_last = (r_state == S_RUN) && (r_cnt == SQ_LAST);

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_roll  <= cordic_init(i_ent.roll_y, i_ent.roll_x);
                        r_yaw   <= cordic_init(i_ent.yaw_y, i_ent.yaw_x);
                        r_t2q   <= i_ent.t2q;
                        r_clp   <= i_ent.clamped;
                        r_sv    <= i_ent.rem;
                        r_sr    <= '0;
                        r_sb    <= 63'd1 << 62;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_sv <= sq_v;
                    r_sr <= sq_r;
                    r_sb <= r_sb >> 2;
                    if (r_cnt <= LAST_IT) begin
                        r_roll <= cordic_step(r_roll, r_cnt);
                        r_yaw  <= cordic_step(r_yaw, r_cnt);
                    end
                    if (r_cnt == SQ_LAST) begin
                        r_pitch <= cordic_init(t_coord'(r_t2q), t_coord'(sq_r));
                        r_cnt   <= '0;
                        r_state <= S_PITCH;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PITCH: begin
                    r_pitch <= cordic_step(r_pitch, r_cnt);
                    if (r_cnt == LAST_IT) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_MUL: begin
                    r_m_roll  <= r_roll.ang * DEG_SCALE;
                    r_m_yaw   <= r_yaw.ang * DEG_SCALE;
                    r_m_pitch <= r_pitch.ang * DEG_SCALE;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    r_o_roll  <= r_roll.zero ? '0 : 16'(to_deg(r_m_roll, 19'sd23040));
                    r_o_yaw   <= r_yaw.zero ? '0 : 16'(to_deg(r_m_yaw, 19'sd23040));
                    r_o_pitch <= r_pitch.zero ? '0 : 15'(to_deg(r_m_pitch, 19'sd11520));
                    r_o_clp   <= r_clp;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_roll_angle    = r_o_roll;
    assign o_pitch_angle   = r_o_pitch;
    assign o_yaw_angle     = r_o_yaw;
    assign o_pitch_clamped = r_o_clp;

    `QTE_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_valid, !r_valid)
    `QTE_ASSERT_IMPLY(a_pitch_range, i_clk, i_rst_n, r_valid, (r_o_pitch <= PITCH_LIM) && (r_o_pitch >= -PITCH_LIM))
    `QTE_ASSERT_NEXT(a_root_done, i_clk, i_rst_n, root_last, r_state == S_PITCH)

endmodule
`default_nettype wire

/* bench/tb_quaternion_to_euler_angles.sv */
`default_nettype none
module tb_quaternion_to_euler_angles;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int QUAT_FRAC_BITS    = 14;
    localparam int N_STEPS           = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam int LATENCY           = N_STEPS + 39;
    localparam int STALL_LIMIT       = 20 * (N_STEPS + 35) + 200;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_q_w = '0;
    logic signed [15:0] i_q_x = '0;
    logic signed [15:0] i_q_y = '0;
    logic signed [15:0] i_q_z = '0;
    logic               o_valid;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;
    logic               o_pitch_clamped;

    t_angles angles_pending[$];
    int      n_errors = 0;
    int      idle_cycles = 0;
    bit      gaps_on = 1'b1;

    always #4 i_clk = ~i_clk;

    quaternion_to_euler_angles #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_q_w(i_q_w), .i_q_x(i_q_x), .i_q_y(i_q_y), .i_q_z(i_q_z),
        .o_valid(o_valid), .o_roll_angle(o_roll_angle),
        .o_pitch_angle(o_pitch_angle), .o_yaw_angle(o_yaw_angle),
        .o_pitch_clamped(o_pitch_clamped)
    );

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_of(longint v);
        int sh;
        sh = 2 * QUAT_FRAC_BITS - 30;
        if (sh >= 0) return v >>> sh;
        return v <<< (-sh);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // atan2 in 1/128 degree; angle accumulator counts 2^-32 turn
    function automatic longint vector_angle(longint y, longint x, longint lim);
        longint arc_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        longint a, xs, ys, d;
        a = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            a = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; a += arc_tab[i];
            end else begin
                x -= ys; y += xs; a -= arc_tab[i];
            end
        end
        d = floor_shift(a * 46080 + (64'sd1 <<< 31), 32);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return d;
    endfunction

    function automatic t_angles euler_of(logic signed [15:0] w, logic signed [15:0] x,
                                         logic signed [15:0] y, logic signed [15:0] z);
        t_angles r;
        longint one, lw, lx, ly, lz, t0, t1, t2, t3, t4, t2q;
        longint unsigned rem;
        lw = w; lx = x; ly = y; lz = z;
        one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
        t0 = one - 2 * (ly * ly + lz * lz);
        t1 = 2 * (lx * ly + lw * lz);
        t2 = 2 * (lw * ly - lx * lz);
        t3 = 2 * (ly * lz + lw * lx);
        t4 = one - 2 * (lx * lx + ly * ly);
        r.clamped = 1'b0;
        if (t2 > one) begin
            t2 = one; r.clamped = 1'b1;
        end else if (t2 < -one) begin
            t2 = -one; r.clamped = 1'b1;
        end
        t2q = q30_of(t2);
        rem = (64'd1 << 60) - longint'(t2q * t2q);
        r.roll  = 16'(vector_angle(q30_of(t3), q30_of(t4), 23040));
        r.pitch = 15'(vector_angle(t2q, root_floor(rem), 11520));
        r.yaw   = 16'(vector_angle(q30_of(t1), q30_of(t0), 23040));
        return r;
    endfunction

    // start stays high after an item is taken; a gap in the next call or the end of
    // the run drops it, so it gets one update per edge
    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        if (gaps_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(15, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_q_w <= w; i_q_x <= x; i_q_y <= y; i_q_z <= z;
        do @(posedge i_clk); while (busy);
        angles_pending.push_back(euler_of(w, x, y, z));
    endtask

    // random unit-ish quaternion, optionally scaled past unity, or raw random components
    task automatic send_rand_quat(bit normal);
        real a, b, c, d, n, s;
        if (!normal) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            a = real'($urandom_range(2000)) - 1000.0;
            b = real'($urandom_range(2000)) - 1000.0;
            c = real'($urandom_range(2000)) - 1000.0;
            d = real'($urandom_range(2000)) - 1000.0;
            n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
            s = 16384.0 * (0.97 + real'($urandom_range(60)) / 1000.0) / n;
            send_quat(16'($rtoi(a * s)), 16'($rtoi(b * s)),
                      16'($rtoi(c * s)), 16'($rtoi(d * s)));
        end
    endtask

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_valid) begin
            if (angles_pending.size() == 0) begin
                $error("result with nothing expected");
                n_errors++;
            end else begin
                e = angles_pending.pop_front();
                if (o_roll_angle !== e.roll) begin
                    $error("roll_angle exp %0d got %0d", e.roll, o_roll_angle); n_errors++;
                end
                if (o_pitch_angle !== e.pitch) begin
                    $error("pitch_angle exp %0d got %0d", e.pitch, o_pitch_angle); n_errors++;
                end
                if (o_yaw_angle !== e.yaw) begin
                    $error("yaw_angle exp %0d got %0d", e.yaw, o_yaw_angle); n_errors++;
                end
                if (o_pitch_clamped !== e.clamped) begin
                    $error("pitch_clamped exp %0d got %0d", e.clamped, o_pitch_clamped);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_quaternion_to_euler_angles: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_quat(16'sd16384, 0, 0, 0);                 // identity
        send_quat(0, 0, 0, 0);                          // zero quaternion
        send_quat(0, 16'sd16384, 0, 0);                 // roll 180
        send_quat(0, 0, 0, 16'sd16384);                 // yaw 180, negative x operand
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(16'sd11585, 0, 16'sd11585, 0);        // pitch +90
        send_quat(16'sd11585, 0, -16'sd11585, 0);       // pitch -90
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 0, 16'sd32767, 0);        // clamp high
        send_quat(16'sd32767, 0, -16'sd32768, 0);       // clamp low
        send_quat(-16'sd32768, 16'sd32767, 0, 0);
        send_quat(0, -16'sd32768, 16'sd32767, 0);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sd16384, 16'sd1, 0, 0);
        send_quat(16'sd16384, -16'sd1, 0, -16'sd1);
        send_quat(-16'sd16384, 0, 0, 16'sd1);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_rand_quat($urandom_range(9) < 7);
    endtask

    task automatic test_back_to_back(int n);
        gaps_on = 1'b0;
        for (int i = 0; i < n; i++) send_rand_quat($urandom_range(9) < 7);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1000);
        test_back_to_back(200);
        start <= 1'b0;
        while (angles_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) $display("tb_quaternion_to_euler_angles: done, clean");
        else $display("tb_quaternion_to_euler_angles: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
